@@ rtl/mgde_pkg.sv @@
// ----------------------------------------------------------------------------
// mgde_pkg
// Shared sizes, types and helpers for the masked grayscale dilate/erode block.
// ----------------------------------------------------------------------------
package mgde_pkg;

    // Image and window sizes
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_MASK    = 5;
    localparam int PIXEL_BITS  = 8;
    localparam int LINES       = MAX_MASK - 1;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROWS_W      = $clog2(LINES + 1);
    localparam int ROWS_INC_W  = ROWS_W + 1;
    localparam int LINE_BITS   = LINES * PIXEL_BITS;

    // Configuration register widths
    localparam int MASK_BITS_W = 25;
    localparam int MSIZE_W     = 3;
    localparam int IMG_W_BITS  = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 25;

    // Output queue sizing
    localparam int OUTQ_DEPTH  = 8;
    localparam int QPTR_W      = $clog2(OUTQ_DEPTH);
    localparam int QCNT_W      = $clog2(OUTQ_DEPTH + 1);
    localparam int CREDIT_W    = $clog2(OUTQ_DEPTH + 4);

    localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE,
        CFG_MASK_BITS,
        CFG_MASK_WIDTH,
        CFG_MASK_HEIGHT,
        CFG_IMAGE_WIDTH
    } t_cfg_index;

    typedef logic [PIXEL_BITS-1:0] t_pixel;
    typedef logic [MAX_MASK-1:0][PIXEL_BITS-1:0] t_column;

    typedef struct packed {
        logic                shift;
        logic                mode;
        logic [MAX_MASK-1:0] row_en;
    } t_cell_ctrl;

    typedef struct packed {
        t_pixel pixel;
        logic   row_last;
    } t_result;

    // Keep the larger (dilate) or smaller (erode) of two pixels
    function automatic t_pixel pick(logic mode, t_pixel a, t_pixel b);
        t_pixel res;
        if (mode) begin
            res = (b < a) ? b : a;
        end else begin
            res = (b > a) ? b : a;
        end
        return res;
    endfunction

endpackage

@@ rtl/mgde_ram.sv @@
// ----------------------------------------------------------------------------
// mgde_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mgde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and read the old contents on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mgde_cell.sv @@
// ----------------------------------------------------------------------------
// mgde_cell
// One window column: holds its pixels, passes them left, reduces its rows.
// ----------------------------------------------------------------------------
module mgde_cell
    import mgde_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_column    i_col,
    output t_column    o_col,
    output t_pixel     o_red
);

    t_column r_col;
    t_pixel  r_red;
    t_pixel  n_red;

    // Take the column from the right-hand neighbor on each word
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_col <= i_col;
        end
    end

    // Reduce the enabled rows, starting from the identity value
    always_comb begin
        n_red = i_ctrl.mode ? PIX_MAX : '0;
        for (int r = 0; r < MAX_MASK; r++) begin
            if (i_ctrl.row_en[r]) begin
                n_red = pick(i_ctrl.mode, n_red, r_col[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_red <= n_red;
    end

    assign o_col = r_col;
    assign o_red = r_red;

endmodule

@@ rtl/mgde_outq.sv @@
// ----------------------------------------------------------------------------
// mgde_outq
// Result queue between the window pipeline and the output handshake.
// ----------------------------------------------------------------------------
module mgde_outq
    import mgde_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_result           i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output t_result           o_head,
    output logic [QCNT_W-1:0] o_count
);

    t_result             r_mem [OUTQ_DEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wptr;
    logic [QPTR_W-1:0]   n_rptr;
    logic [QCNT_W-1:0]   n_count;
    logic                pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    // Advance pointers with wrap and track fill level
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QPTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop_ok) begin
            n_rptr = (r_rptr == QPTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

@@ rtl/masked_grayscale_dilate_erode.sv @@
// ----------------------------------------------------------------------------
// masked_grayscale_dilate_erode
// Pipeline: a result word is offered once its accepted pixel has passed the
// line RAM read, window column reduce and cross-column reduce into the queue.
// Throughput: one pixel per cycle, limited by the single line RAM port pair;
// input stalls only when the 8-entry result queue plus in-flight words is full.
// Reset: synchronous, active low; clears counters, pipeline and queue and loads
// the default configuration. Line RAM contents are left as they are.
// ----------------------------------------------------------------------------
module masked_grayscale_dilate_erode
    import mgde_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Pixel input
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic                  i_frame_start,
    // Result output
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIXEL_BITS-1:0] o_out_pixel,
    output logic                  o_row_last,
    // Configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic                   r_mode;
    logic [MASK_BITS_W-1:0] r_mask_bits;
    logic [MSIZE_W-1:0]     r_mask_width;
    logic [MSIZE_W-1:0]     r_mask_height;
    logic [IMG_W_BITS-1:0]  r_image_width;

    logic [MSIZE_W-1:0]     mw;
    logic [MSIZE_W-1:0]     mh;
    logic [IMG_W_BITS-1:0]  iw;

    // Position counters
    logic [COL_BITS-1:0]    r_col;
    logic [ROWS_W-1:0]      r_rows;
    logic [COL_BITS-1:0]    n_col;
    logic [ROWS_W-1:0]      n_rows;
    logic [COL_BITS-1:0]    cur_col;
    logic [ROWS_W-1:0]      cur_rows;
    logic [IMG_W_BITS-1:0]  col_inc;
    logic [ROWS_INC_W-1:0]  rows_inc;
    logic                   in_fire;
    logic                   emit;
    logic                   last;

    // Stage 1: line RAM read
    logic                   r_s1_valid;
    logic                   r_s1_emit;
    logic                   r_s1_last;
    t_pixel                 r_s1_pix;
    logic [COL_BITS-1:0]    r_s1_addr;
    logic                   r_fwd_hit;
    logic [LINE_BITS-1:0]   r_fwd_data;
    logic [LINE_BITS-1:0]   ram_rdata;
    logic [LINE_BITS-1:0]   rd_word;
    logic [LINE_BITS-1:0]   wr_word;
    t_column                newcol;

    // Stages 2 and 3
    logic                   r_s2_emit;
    logic                   r_s2_last;
    logic                   r_s3_emit;
    logic                   r_s3_last;

    // Window cells
    t_column                cell_in  [MAX_MASK];
    t_column                cell_out [MAX_MASK];
    t_pixel                 cell_red [MAX_MASK];
    t_cell_ctrl             cell_ctrl[MAX_MASK];
    t_pixel                 best;

    // Result queue and flow control
    t_result                q_head;
    t_result                q_push_data;
    logic                   q_pop;
    logic [QCNT_W-1:0]      q_count;
    logic [1:0]             inflight;
    logic [CREDIT_W-1:0]    used;

    // Mask position enable for window row r, column c
    function automatic logic pos_en(int r, int c, logic [MSIZE_W-1:0] w,
                                    logic [MSIZE_W-1:0] h,
                                    logic [MASK_BITS_W-1:0] bits);
        int                     my;
        int                     mx;
        int                     k;
        logic [MASK_BITS_W-1:0] sh;
        my = r - (MAX_MASK - int'(h));
        mx = c - (MAX_MASK - int'(w));
        if (my < 0 || mx < 0) begin
            return 1'b0;
        end
        k = my * int'(w) + mx;
        if (k >= MASK_BITS_W) begin
            return 1'b0;
        end
        sh = bits >> k;
        return sh[0];
    endfunction

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= 1'b0;
            r_mask_bits   <= MASK_BITS_W'(511);
            r_mask_width  <= MSIZE_W'(3);
            r_mask_height <= MSIZE_W'(3);
            r_image_width <= IMG_W_BITS'(640);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MODE:        r_mode        <= i_cfg_data[0];
                CFG_MASK_BITS:   r_mask_bits   <= i_cfg_data[MASK_BITS_W-1:0];
                CFG_MASK_WIDTH:  r_mask_width  <= i_cfg_data[MSIZE_W-1:0];
                CFG_MASK_HEIGHT: r_mask_height <= i_cfg_data[MSIZE_W-1:0];
                CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data[IMG_W_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamp sizes into their legal ranges
    always_comb begin
        if (r_mask_width == '0) begin
            mw = MSIZE_W'(1);
        end else if (r_mask_width > MSIZE_W'(MAX_MASK)) begin
            mw = MSIZE_W'(MAX_MASK);
        end else begin
            mw = r_mask_width;
        end
        if (r_mask_height == '0) begin
            mh = MSIZE_W'(1);
        end else if (r_mask_height > MSIZE_W'(MAX_MASK)) begin
            mh = MSIZE_W'(MAX_MASK);
        end else begin
            mh = r_mask_height;
        end
        if (r_image_width == '0) begin
            iw = IMG_W_BITS'(1);
        end else if (r_image_width > IMG_W_BITS'(MAX_WIDTH)) begin
            iw = IMG_W_BITS'(MAX_WIDTH);
        end else begin
            iw = r_image_width;
        end
    end

    // Accept: decide emission and row end, advance position
    assign in_fire  = i_valid && o_ready;
    assign cur_col  = i_frame_start ? '0 : r_col;
    assign cur_rows = i_frame_start ? '0 : r_rows;
    assign col_inc  = IMG_W_BITS'(cur_col) + IMG_W_BITS'(1);
    assign rows_inc = ROWS_INC_W'(cur_rows) + ROWS_INC_W'(1);
    assign emit     = (col_inc >= IMG_W_BITS'(mw)) && (rows_inc >= ROWS_INC_W'(mh));
    assign last     = (col_inc >= iw);

    always_comb begin
        n_col  = r_col;
        n_rows = r_rows;
        if (in_fire) begin
            if (last) begin
                n_col  = '0;
                n_rows = (cur_rows < ROWS_W'(LINES)) ? cur_rows + 1'b1 : cur_rows;
            end else begin
                n_col  = col_inc[COL_BITS-1:0];
                n_rows = cur_rows;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_rows     <= '0;
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
            r_s2_emit  <= 1'b0;
            r_s3_emit  <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_rows     <= n_rows;
            r_s1_valid <= in_fire;
            r_s1_emit  <= in_fire && emit;
            r_s2_emit  <= r_s1_emit;
            r_s3_emit  <= r_s2_emit;
            r_fwd_hit  <= r_s1_valid && in_fire && (cur_col == r_s1_addr);
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_last  <= last;
        r_s1_pix   <= i_pixel;
        r_s1_addr  <= cur_col;
        r_fwd_data <= wr_word;
        r_s2_last  <= r_s1_last;
        r_s3_last  <= r_s2_last;
    end

    // Line storage: one word per column, newest line in the low byte
    mgde_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (wr_word),
        .i_raddr (cur_col),
        .o_rdata (ram_rdata)
    );

    // Forward the previous write when the same column is read back to back
    assign rd_word = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign wr_word = {rd_word[LINE_BITS-PIXEL_BITS-1:0], r_s1_pix};

    // Build the new window column, oldest line on top
    always_comb begin
        for (int r = 0; r < LINES; r++) begin
            newcol[r] = rd_word[(LINES-1-r)*PIXEL_BITS +: PIXEL_BITS];
        end
        newcol[MAX_MASK-1] = r_s1_pix;
    end

    // Chain of window cells, new column enters on the right
    for (genvar c = 0; c < MAX_MASK; c++) begin : g_cell
        if (c == MAX_MASK - 1) begin : g_right
            assign cell_in[c] = newcol;
        end else begin : g_inner
            assign cell_in[c] = cell_out[c+1];
        end

        always_comb begin
            cell_ctrl[c].shift = r_s1_valid;
            cell_ctrl[c].mode  = r_mode;
            for (int r = 0; r < MAX_MASK; r++) begin
                cell_ctrl[c].row_en[r] = pos_en(r, c, mw, mh, r_mask_bits);
            end
        end

        mgde_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (cell_ctrl[c]),
            .i_col  (cell_in[c]),
            .o_col  (cell_out[c]),
            .o_red  (cell_red[c])
        );
    end

    // Combine the column results
    always_comb begin
        best = r_mode ? PIX_MAX : '0;
        for (int c = 0; c < MAX_MASK; c++) begin
            best = pick(r_mode, best, cell_red[c]);
        end
    end

    assign q_push_data.pixel    = best;
    assign q_push_data.row_last = r_s3_last;
    assign q_pop                = o_valid && i_ready;

    mgde_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s3_emit),
        .i_data  (q_push_data),
        .i_pop   (q_pop),
        .o_valid (o_valid),
        .o_head  (q_head),
        .o_count (q_count)
    );

    // Hold input when queued plus in-flight words would overrun the queue
    assign inflight = 2'(r_s1_emit) + 2'(r_s2_emit) + 2'(r_s3_emit);
    assign used     = CREDIT_W'(q_count) + CREDIT_W'(inflight);
    assign o_ready  = (used < CREDIT_W'(OUTQ_DEPTH));

    assign o_out_pixel = q_head.pixel;
    assign o_row_last  = q_head.row_last;

`ifndef SYNTH
    // A pushed word always finds room in the queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_emit |-> (q_count < QCNT_W'(OUTQ_DEPTH)) || q_pop)
        else $error("result queue overflow");

    // Queued plus in-flight words never exceed the queue depth
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used <= CREDIT_W'(OUTQ_DEPTH))
        else $error("credit count exceeds queue depth");

    // An emitting word travels through every stage without loss
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_emit |=> r_s2_emit ##1 r_s3_emit)
        else $error("emitting word lost in pipeline");
`endif

endmodule

@@ tb/sv/tb_masked_grayscale_dilate_erode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_masked_grayscale_dilate_erode
// Streams raster pixels into the masked dilate/erode block under random sender
// bursts and receiver stalls. A scoreboard model of line rows, window and
// counters predicts every result word, which is checked field by field.
// ----------------------------------------------------------------------------
module tb_masked_grayscale_dilate_erode;
    import mgde_pkg::*;

    localparam int RANDOM_PIXELS = 150;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS   = 50;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_style;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [PIXEL_BITS-1:0] i_pixel;
    logic                  i_frame_start;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [PIXEL_BITS-1:0] o_out_pixel;
    logic                  o_row_last;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Scoreboard copy of the configuration
    logic                   morph_mode;
    logic [MASK_BITS_W-1:0] se_bits;
    logic [MSIZE_W-1:0]     se_width;
    logic [MSIZE_W-1:0]     se_height;
    logic [IMG_W_BITS-1:0]  line_width;

    // Scoreboard copy of line rows, window and counters
    t_pixel  line_mem [LINES][MAX_WIDTH];
    t_pixel  win [MAX_MASK][MAX_MASK];
    int      col_pos;
    int      rows_done;
    t_result expected_words[$];

    int        errors        = 0;
    int        words_checked = 0;
    int        pixels_sent   = 0;
    int        reg_writes    = 0;
    int        burst_left    = 0;
    int        rx_left       = 0;
    t_rx_style rx_style      = RX_FREE;

    masked_grayscale_dilate_erode u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_pixel   (o_out_pixel),
        .o_row_last    (o_row_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock: 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop if the stream hangs
    initial begin
        #5_000_000;
        $display("Timeout at %0t", $time);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int clip_size(input int v, input int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // Pixel value, biased toward the two rails
    function automatic t_pixel random_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return PIX_MAX;
            default: return t_pixel'($urandom);
        endcase
    endfunction

    // Mask size, mostly in range, sometimes zero or past the maximum
    function automatic int random_dim();
        int pick;
        pick = $urandom_range(0, 2);
        if ($urandom_range(0, 6) != 0) begin
            return $urandom_range(1, MAX_MASK);
        end
        return (pick == 0) ? 0 : pick + 5;
    endfunction

    // Advance the scoreboard by one pixel; queue the result word it causes
    function automatic void dilate_erode_step(input t_pixel pix, input logic fs);
        int      mw;
        int      mh;
        int      iw;
        int      x;
        int      col;
        int      k;
        t_pixel  fresh [MAX_MASK];
        t_pixel  best;
        t_pixel  v;
        t_result word;

        mw = clip_size(se_width, MAX_MASK);
        mh = clip_size(se_height, MAX_MASK);
        iw = clip_size(line_width, MAX_WIDTH);
        if (fs) begin
            col_pos   = 0;
            rows_done = 0;
        end
        x = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;

        // New window column: oldest row on top, current pixel at the bottom
        for (int r = 0; r < LINES; r++) fresh[r] = line_mem[LINES-1-r][x];
        fresh[MAX_MASK-1] = pix;
        for (int r = LINES - 1; r > 0; r--) line_mem[r][x] = line_mem[r-1][x];
        line_mem[0][x] = pix;

        // Shift window left and insert the new column
        for (int r = 0; r < MAX_MASK; r++) begin
            for (int c = 0; c < MAX_MASK - 1; c++) win[r][c] = win[r][c+1];
            win[r][MAX_MASK-1] = fresh[r];
        end

        col = col_pos;
        if (col + 1 >= mw && rows_done + 1 >= mh) begin
            best = morph_mode ? PIX_MAX : '0;
            for (int my = 0; my < mh; my++) begin
                for (int mx = 0; mx < mw; mx++) begin
                    k = my * mw + mx;
                    if (k < MASK_BITS_W && se_bits[k]) begin
                        v = win[MAX_MASK-mh+my][MAX_MASK-mw+mx];
                        if (morph_mode ? (v < best) : (v > best)) best = v;
                    end
                end
            end
            word.pixel    = best;
            word.row_last = (col + 1 >= iw);
            expected_words.push_back(word);
        end

        if (col + 1 >= iw) begin
            col_pos = 0;
            if (rows_done < LINES) rows_done++;
        end else begin
            col_pos = col + 1;
        end
    endfunction

    // Send one pixel word; gaps fall between bursts of random length
    task automatic send_pixel(input t_pixel pix, input logic fs);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_pixel       <= pix;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        dilate_erode_step(pix, fs);
        pixels_sent++;
    endtask

    // Hold the sender until every expected word is out and the pipe is empty
    task automatic settle_block();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_MODE:        morph_mode = data[0];
            CFG_MASK_BITS:   se_bits    = data[MASK_BITS_W-1:0];
            CFG_MASK_WIDTH:  se_width   = data[MSIZE_W-1:0];
            CFG_MASK_HEIGHT: se_height  = data[MSIZE_W-1:0];
            CFG_IMAGE_WIDTH: line_width = data[IMG_W_BITS-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Reset configuration and counters: 3x3 dilate over 640-pixel rows
    task automatic test_reset_defaults();
        for (int i = 0; i < 2 * 640 + 12; i++) send_pixel(random_pixel(), 1'b0);
    endtask

    // Zero image width and zero mask size act as one: every pixel is a row
    task automatic test_unit_window();
        t_pixel ramp [6];
        ramp = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
        settle_block();
        write_reg(CFG_IMAGE_WIDTH, 25'd0);
        write_reg(CFG_MASK_WIDTH, 25'd0);
        write_reg(CFG_MASK_HEIGHT, 25'd0);
        write_reg(CFG_MASK_BITS, 25'd1);
        write_reg(CFG_MODE, 25'd1);
        for (int i = 0; i < 6; i++) send_pixel(ramp[i], i == 0);
        settle_block();
        write_reg(CFG_MODE, 25'd0);
        for (int i = 0; i < 3; i++) send_pixel(ramp[5-i], 1'b0);
    endtask

    // Empty mask, including bits past width*height, gives the start value
    task automatic test_empty_mask();
        settle_block();
        write_reg(CFG_IMAGE_WIDTH, 25'd4);
        write_reg(CFG_MASK_WIDTH, 25'd3);
        write_reg(CFG_MASK_HEIGHT, 25'd2);
        write_reg(CFG_MASK_BITS, 25'h1FFFFC0);
        write_reg(CFG_MODE, 25'd1);
        for (int i = 0; i < 8; i++) send_pixel(random_pixel(), i == 0);
        settle_block();
        write_reg(CFG_MODE, 25'd0);
        for (int i = 0; i < 4; i++) send_pixel(random_pixel(), 1'b0);
    endtask

    // Mask sizes past the maximum saturate to a full 5x5 window
    task automatic test_oversize_mask();
        settle_block();
        write_reg(CFG_IMAGE_WIDTH, 25'd5);
        write_reg(CFG_MASK_WIDTH, 25'd7);
        write_reg(CFG_MASK_HEIGHT, 25'd6);
        write_reg(CFG_MASK_BITS, 25'h1FFFFFF);
        for (int i = 0; i < 25; i++) send_pixel(random_pixel(), i == 0);
        settle_block();
        write_reg(CFG_MODE, 25'd1);
        for (int i = 0; i < 5; i++) send_pixel(random_pixel(), 1'b0);
    endtask

    // Width cut below the current column ends the row on the next pixel
    task automatic test_width_shrink_midrow();
        settle_block();
        write_reg(CFG_IMAGE_WIDTH, 25'd10);
        write_reg(CFG_MASK_WIDTH, 25'd2);
        write_reg(CFG_MASK_HEIGHT, 25'd2);
        write_reg(CFG_MASK_BITS, 25'h9);
        write_reg(CFG_MODE, 25'd0);
        for (int i = 0; i < 16; i++) send_pixel(random_pixel(), i == 0);
        settle_block();
        write_reg(CFG_IMAGE_WIDTH, 25'd4);
        for (int i = 0; i < 9; i++) send_pixel(random_pixel(), 1'b0);
    endtask

    // Frame start in the middle of a row clears column and row counts
    task automatic test_frame_restart();
        settle_block();
        write_reg(CFG_IMAGE_WIDTH, 25'd6);
        write_reg(CFG_MASK_WIDTH, 25'd3);
        write_reg(CFG_MASK_HEIGHT, 25'd3);
        write_reg(CFG_MASK_BITS, 25'($urandom_range(1, 511)));
        write_reg(CFG_MODE, 25'd1);
        for (int i = 0; i < 20; i++) send_pixel(random_pixel(), i == 0);
        for (int i = 0; i < 18; i++) send_pixel(random_pixel(), i == 0);
    endtask

    // Random phases: new settings, then whole frames with random content
    task automatic test_random_stream(input int target);
        int   sent;
        int   eff_before;
        int   eff_after;
        int   mh;
        int   n_items;
        int   w;
        logic fs;

        sent = 0;
        while (sent < target) begin
            settle_block();
            eff_before = clip_size(line_width, MAX_WIDTH);
            if ($urandom_range(0, 1)) write_reg(CFG_MODE, 25'($urandom_range(0, 1)));
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 5))
                    0: write_reg(CFG_MASK_BITS, 25'h1FFFFFF);
                    1: write_reg(CFG_MASK_BITS, 25'd0);
                    2: write_reg(CFG_MASK_BITS, 25'd1 << $urandom_range(0, 24));
                    default: write_reg(CFG_MASK_BITS, 25'($urandom));
                endcase
            end
            if ($urandom_range(0, 1)) write_reg(CFG_MASK_WIDTH, 25'(random_dim()));
            if ($urandom_range(0, 1)) write_reg(CFG_MASK_HEIGHT, 25'(random_dim()));
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 9))
                    0:       w = 0;
                    1, 2:    w = $urandom_range(13, 40);
                    default: w = $urandom_range(1, 12);
                endcase
                write_reg(CFG_IMAGE_WIDTH, 25'(w));
            end
            eff_after = clip_size(line_width, MAX_WIDTH);
            mh        = clip_size(se_height, MAX_MASK);

            // A wider row needs a fresh frame so no unwritten line entry is used
            fs      = (eff_after > eff_before) || ($urandom_range(0, 3) == 0);
            n_items = eff_after * (mh + $urandom_range(1, 4)) + $urandom_range(0, eff_after);
            for (int i = 0; i < n_items; i++) begin
                send_pixel(random_pixel(), fs);
                fs = ($urandom_range(0, 149) == 0);
            end
            sent += n_items;
        end
    endtask

    // Receiver stalls, with a new random style after each run of random length
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            rx_left  = $urandom_range(50, 300);
        end
        rx_left--;
        case (rx_style)
            RX_FREE:   i_ready <= 1'b1;
            RX_COIN:   i_ready <= ($urandom_range(0, 1) == 0);
            RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
            default:   i_ready <= (rx_left % 16) < 11;
        endcase
    end

    // Check each accepted result word against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (expected_words.size() == 0) begin
                if (errors < MAX_REPORTS) begin
                    $display("%0t: unexpected word: expected none, actual pixel=%0d row_last=%0b",
                             $time, o_out_pixel, o_row_last);
                end
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (o_out_pixel !== want.pixel) begin
                    if (errors < MAX_REPORTS) begin
                        $display("%0t: out_pixel mismatch: expected %0d, actual %0d",
                                 $time, want.pixel, o_out_pixel);
                    end
                    errors++;
                end
                if (o_row_last !== want.row_last) begin
                    if (errors < MAX_REPORTS) begin
                        $display("%0t: row_last mismatch: expected %0b, actual %0b",
                                 $time, want.row_last, o_row_last);
                    end
                    errors++;
                end
                words_checked++;
            end
        end
    end

    initial begin
        // Scoreboard starts from the reset state
        morph_mode = 1'b0;
        se_bits    = 25'd511;
        se_width   = 3'd3;
        se_height  = 3'd3;
        line_width = 11'd640;
        col_pos    = 0;
        rows_done  = 0;
        for (int r = 0; r < LINES; r++) begin
            for (int c = 0; c < MAX_WIDTH; c++) line_mem[r][c] = '0;
        end
        for (int r = 0; r < MAX_MASK; r++) begin
            for (int c = 0; c < MAX_MASK; c++) win[r][c] = '0;
        end

        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_pixel       <= '0;
        i_frame_start <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_MODE;
        i_cfg_data    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_unit_window();
        test_empty_mask();
        test_oversize_mask();
        test_width_shrink_midrow();
        test_frame_restart();
        test_random_stream(RANDOM_PIXELS);

        // Drain, then wait on for any stray word
        settle_block();
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d pixels, %0d result words, %0d register writes",
                 pixels_sent, words_checked, reg_writes);
        $display("over dilate and erode, masks empty to 5x5, widths 1 to 640, cuts and restarts");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mgde_pkg.sv
rtl/mgde_ram.sv
rtl/mgde_cell.sv
rtl/mgde_outq.sv
rtl/masked_grayscale_dilate_erode.sv
tb/sv/tb_masked_grayscale_dilate_erode.sv
